/* design/sliding_window_box_mean_unit_defines.svh */
// Assertion macros for the sliding window box mean unit
`ifndef SLIDING_WINDOW_BOX_MEAN_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_BOX_MEAN_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SWBM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWBM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define SWBM_ASSERT(label, clk, rst_n, prop, msg)
`define SWBM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* design/swbm_pkg.sv */
// Shared constants and types of the sliding window box mean unit
`default_nettype none
package swbm_pkg;
	localparam int MAX_COLS = 1024;
	localparam int MAX_WIN = 16;
	localparam int PIXEL_BITS = 8;
	localparam int MAX_IMG_ROWS = 4096;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ROW_W = 12;
	localparam int SLOT_W = $clog2(MAX_WIN);
	localparam int CS_W = PIXEL_BITS + 4;
	localparam int WS_W = PIXEL_BITS + 8;
	localparam int HIST_DEPTH = MAX_COLS * MAX_WIN;
	localparam int HIST_AW = $clog2(HIST_DEPTH);
	localparam int AREA_W = 9;
	localparam int NUM_W = WS_W + 8;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [1:0] REG_WIN_COLS = 2'd0;
	localparam logic [1:0] REG_WIN_ROWS = 2'd1;
	localparam logic [1:0] REG_IMG_COLS = 2'd2;
	localparam logic [1:0] REG_IMG_ROWS = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic rd;
		logic upd;
		logic div_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic div_busy;
		logic out_full;
	} sts_t;
endpackage
`default_nettype wire

/* design/swbm_ram.sv */
// Generic single-port-write RAM with registered read
`default_nettype none
module swbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* design/swbm_ctrl.sv */
// Controller state machine of the box mean unit
`default_nettype none
module swbm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              out_stall,
	input  wire swbm_pkg::sts_t    sts,
	output swbm_pkg::cmd_t         cmd
);
	import swbm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_READ;
			ST_READ: state_d = ST_SUM;
			ST_SUM: state_d = sts.emit ? ST_DIV : ST_IDLE;
			ST_DIV: if (!sts.div_busy) state_d = ST_OUT;
			ST_OUT: if (!sts.out_full || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			ST_READ: cmd.rd = 1'b1;
			ST_SUM: begin
				cmd.upd = 1'b1;
				cmd.div_start = sts.emit;
			end
			ST_DIV: ;
			ST_OUT: cmd.out_load = !sts.out_full || !out_stall;
			default: ;
		endcase
	end

	`include "sliding_window_box_mean_unit_defines.svh"
	`SWBM_ASSERT(a_stall_busy, clk, arst_n, (state_q != ST_IDLE) -> in_stall, "busy without stall")
	`SWBM_ASSERT_NEXT(a_read_sum, clk, arst_n, state_q == ST_READ, state_q == ST_SUM, "read not followed by sum")
	`SWBM_ASSERT(a_div_ok, clk, arst_n, cmd.out_load -> !sts.div_busy, "load while dividing")
endmodule
`default_nettype wire

/* design/swbm_dp.sv */
// Datapath of the box mean unit: line buffer, sums, divider, output register
`default_nettype none
module swbm_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire swbm_pkg::cmd_t              cmd,
	output swbm_pkg::sts_t                   sts,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_idx,
	input  wire logic [12:0]                 cfg_data,
	input  wire logic [swbm_pkg::PIXEL_BITS-1:0] pixel,
	input  wire logic                        frame_start,
	input  wire logic                        out_stall,
	output logic                             out_valid,
	output logic [15:0]                      mean_fixed,
	output logic [swbm_pkg::COL_W-1:0]       win_col,
	output logic [swbm_pkg::ROW_W-1:0]       win_row,
	output logic                             frame_done
);
	import swbm_pkg::*;

	logic [4:0] wcols_q, wrows_q;
	logic [10:0] icols_q;
	logic [12:0] irows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcols_q <= 5'd3;
			wrows_q <= 5'd3;
			icols_q <= 11'd640;
			irows_q <= 13'd480;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WIN_COLS: wcols_q <= cfg_data[4:0];
				REG_WIN_ROWS: wrows_q <= cfg_data[4:0];
				REG_IMG_COLS: icols_q <= cfg_data[10:0];
				REG_IMG_ROWS: irows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [4:0] wc, wr;
	logic [10:0] ic;
	logic [12:0] ir;
	always_comb begin
		wc = (wcols_q == '0) ? 5'd1 : (wcols_q > 5'(MAX_WIN)) ? 5'(MAX_WIN) : wcols_q;
		wr = (wrows_q == '0) ? 5'd1 : (wrows_q > 5'(MAX_WIN)) ? 5'(MAX_WIN) : wrows_q;
		ic = (icols_q == '0) ? 11'd1 : (icols_q > 11'(MAX_COLS)) ? 11'(MAX_COLS) : icols_q;
		ir = (irows_q == '0) ? 13'd1 : (irows_q > 13'(MAX_IMG_ROWS)) ? 13'(MAX_IMG_ROWS)
			: irows_q;
	end

	logic [COL_W:0] ccol_q;
	logic [ROW_W:0] crow_q;
	logic [COL_W:0] c0;
	logic [ROW_W:0] r0, r1;
	always_comb begin
		c0 = frame_start ? '0 : ccol_q;
		r0 = frame_start ? '0 : crow_q;
		if ({1'b0, c0} >= 12'(ic)) begin
			c0 = '0;
			r0 = r0 + 1'b1;
		end
		r1 = (14'(r0) >= 14'(ir)) ? '0 : r0;
	end

	logic [COL_W-1:0] c_s1;
	logic [ROW_W-1:0] r_s1;
	logic [PIXEL_BITS-1:0] p_s1;

	logic [SLOT_W-1:0] old_slot;
	assign old_slot = SLOT_W'(r_s1[SLOT_W-1:0] - wr[SLOT_W-1:0]);

	logic [PIXEL_BITS-1:0] hist_rd;
	logic [CS_W-1:0] csum_rd;
	logic [CS_W-1:0] cs;

	swbm_ram #(.WIDTH(PIXEL_BITS), .DEPTH(HIST_DEPTH)) u_hist (
		.clk(clk),
		.we(cmd.upd),
		.waddr({r_s1[SLOT_W-1:0], c_s1}),
		.wdata(p_s1),
		.raddr({old_slot, c_s1}),
		.rdata(hist_rd)
	);

	swbm_ram #(.WIDTH(CS_W), .DEPTH(MAX_COLS)) u_csum (
		.clk(clk),
		.we(cmd.upd),
		.waddr(c_s1),
		.wdata(cs),
		.raddr(c_s1),
		.rdata(csum_rd)
	);

	logic [CS_W-1:0] recent_q [MAX_WIN];
	logic [WS_W-1:0] wsum_q, wsum_d;
	logic emit;

	always_comb begin
		if (r_s1 == '0) begin
			cs = CS_W'(p_s1);
		end else if (13'(r_s1) < 13'(wr)) begin
			cs = csum_rd + CS_W'(p_s1);
		end else begin
			cs = csum_rd + CS_W'(p_s1) - CS_W'(hist_rd);
		end
		if (c_s1 == '0) begin
			wsum_d = WS_W'(cs);
		end else if (11'(c_s1) < 11'(wc)) begin
			wsum_d = wsum_q + WS_W'(cs);
		end else begin
			wsum_d = wsum_q + WS_W'(cs)
				- WS_W'(recent_q[SLOT_W'(c_s1 - COL_W'(wc))]);
		end
		emit = (13'(r_s1) + 13'd1 >= 13'(wr)) && (11'(c_s1) + 11'd1 >= 11'(wc));
	end
	assign sts.emit = emit;

	logic [COL_W-1:0] wcol_q;
	logic [ROW_W-1:0] wrow_q;
	logic fdone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccol_q <= '0;
			crow_q <= '0;
			wsum_q <= '0;
			for (int i = 0; i < MAX_WIN; i++) recent_q[i] <= '0;
		end else begin
			if (cmd.take) begin
				c_s1 <= c0[COL_W-1:0];
				r_s1 <= r1[ROW_W-1:0];
				p_s1 <= pixel;
				if ({1'b0, c0} + 12'd1 >= 12'(ic)) begin
					ccol_q <= '0;
					crow_q <= (14'(r1) + 14'd1 >= 14'(ir)) ? '0 : r1 + 1'b1;
				end else begin
					ccol_q <= c0 + 1'b1;
					crow_q <= r1;
				end
			end
			if (cmd.upd) begin
				wsum_q <= wsum_d;
				recent_q[c_s1[SLOT_W-1:0]] <= cs;
				wcol_q <= COL_W'(11'(c_s1) + 11'd1 - 11'(wc));
				wrow_q <= ROW_W'(13'(r_s1) + 13'd1 - 13'(wr));
				fdone_q <= (11'(c_s1) + 11'd1 == ic) && (13'(r_s1) + 13'd1 == ir);
			end
		end
	end

	// restoring divider: (wsum << 8) / (wc * wr), one quotient bit per cycle
	logic [AREA_W-1:0] area_q;
	logic [NUM_W-1:0] quo_q;
	logic [AREA_W:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [AREA_W+1:0] trial;
	assign trial = {rem_q, quo_q[NUM_W-1]} - {2'b0, area_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= DIV_CNT_W'(DIV_STEPS);
			quo_q <= {wsum_d, 8'd0};
			rem_q <= '0;
			area_q <= AREA_W'(wc) * AREA_W'(wr);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (!trial[AREA_W+1]) begin
				rem_q <= trial[AREA_W:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[AREA_W-1:0], quo_q[NUM_W-1]};
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end
	assign sts.div_busy = (cnt_q != '0) || cmd.div_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cmd.out_load) begin
				out_valid <= 1'b1;
				mean_fixed <= quo_q[15:0];
				win_col <= wcol_q;
				win_row <= wrow_q;
				frame_done <= fdone_q;
			end
		end
	end
	assign sts.out_full = out_valid;

	`include "sliding_window_box_mean_unit_defines.svh"
	`SWBM_ASSERT(a_ccol_range, clk, arst_n, 12'(ccol_q) <= 12'(MAX_COLS), "column out of range")
	`SWBM_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.out_load, out_valid, "load lost")
	`SWBM_ASSERT(a_no_overwrite, clk, arst_n, cmd.out_load -> (!out_valid || !out_stall), "overwrite")
endmodule
`default_nettype wire

/* design/sliding_window_box_mean_unit.sv */
// Top level of the sliding window box mean unit
// Takes raster pixels and emits the 8.8 mean of every window that fits in the image.
// A pixel that closes no window passes accept, line buffer read and sum update; one
// that closes one also runs the restoring divider, one quotient bit per cycle over
// 24 bits, then loads the result register, waiting while it is held by out_stall.
// No clearing pass after reset.
`default_nettype none
module sliding_window_box_mean_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_idx,
	input  wire logic [12:0]                     cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [swbm_pkg::PIXEL_BITS-1:0] pixel,
	input  wire logic                            frame_start,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [15:0]                          mean_fixed,
	output logic [swbm_pkg::COL_W-1:0]           win_col,
	output logic [swbm_pkg::ROW_W-1:0]           win_row,
	output logic                                 frame_done
);
	import swbm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	swbm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_stall(out_stall),
		.sts(sts),
		.cmd(cmd)
	);

	swbm_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.pixel(pixel),
		.frame_start(frame_start),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.mean_fixed(mean_fixed),
		.win_col(win_col),
		.win_row(win_row),
		.frame_done(frame_done)
	);
endmodule
`default_nettype wire

/* tb/sv/swbm_checker.sv */
// Checker for the sliding window box mean unit: predicts window means and compares results
`default_nettype none
module swbm_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  pixel,
	input  wire logic        frame_start,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [15:0] mean_fixed,
	input  wire logic [9:0]  win_col,
	input  wire logic [11:0] win_row,
	input  wire logic        frame_done,
	output int               errors,
	output int               outstanding
);
	import swbm_pkg::*;

	typedef struct packed {
		logic [15:0] mean;
		logic [9:0]  col;
		logic [11:0] row;
		logic        done;
	} window_mean_t;

	window_mean_t mean_q[$];

	logic [4:0]  win_cols_r, win_rows_r;
	logic [10:0] img_cols_r;
	logic [12:0] img_rows_r;
	logic [7:0]  line_hist[HIST_DEPTH];
	logic [11:0] col_sum[MAX_COLS];
	logic [11:0] recent_sum[MAX_WIN];
	logic [15:0] win_sum;
	int          cur_col, cur_row;

	function automatic int clamp_reg(input int v, input int hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	task automatic advance_window(input logic [7:0] p, input logic fs);
		int wc, wr, ic, ir, c, r, oslot;
		logic [11:0] cs;
		longint area, m;
		window_mean_t e;
		wc = clamp_reg(win_cols_r, MAX_WIN);
		wr = clamp_reg(win_rows_r, MAX_WIN);
		ic = clamp_reg(img_cols_r, MAX_COLS);
		ir = clamp_reg(img_rows_r, MAX_IMG_ROWS);
		if (fs) begin
			cur_col = 0;
			cur_row = 0;
		end
		if (cur_col >= ic) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= ir) cur_row = 0;
		c = cur_col;
		r = cur_row;
		if (r == 0) begin
			cs = 12'(p);
		end else if (r < wr) begin
			cs = col_sum[c] + 12'(p);
		end else begin
			oslot = (r + MAX_WIN - wr) % MAX_WIN;
			cs = col_sum[c] + 12'(p) - 12'(line_hist[oslot * MAX_COLS + c]);
		end
		col_sum[c] = cs;
		line_hist[(r % MAX_WIN) * MAX_COLS + c] = p;
		if (c == 0) win_sum = 16'(cs);
		else if (c < wc) win_sum = win_sum + 16'(cs);
		else win_sum = win_sum + 16'(cs) - 16'(recent_sum[(c - wc) % MAX_WIN]);
		recent_sum[c % MAX_WIN] = cs;
		if (r + 1 >= wr && c + 1 >= wc) begin
			area = longint'(wc) * longint'(wr);
			m = (longint'(win_sum) << 8) / area;
			e.mean = 16'(m);
			e.col = 10'(c + 1 - wc);
			e.row = 12'(r + 1 - wr);
			e.done = (c + 1 == ic && r + 1 == ir);
			mean_q.push_back(e);
		end
		cur_col = c + 1;
		if (cur_col >= ic) begin
			cur_col = 0;
			cur_row = r + 1;
			if (cur_row >= ir) cur_row = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_mean_t e;
		if (!arst_n) begin
			win_cols_r <= 5'd3;
			win_rows_r <= 5'd3;
			img_cols_r <= 11'd640;
			img_rows_r <= 13'd480;
			for (int i = 0; i < MAX_WIN; i++) recent_sum[i] = '0;
			win_sum = '0;
			cur_col = 0;
			cur_row = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_WIN_COLS: win_cols_r <= cfg_data[4:0];
					REG_WIN_ROWS: win_rows_r <= cfg_data[4:0];
					REG_IMG_COLS: img_cols_r <= cfg_data[10:0];
					REG_IMG_ROWS: img_rows_r <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) advance_window(pixel, frame_start);
			if (out_valid && !out_stall) begin
				if (mean_q.size() == 0) begin
					$display("%0t: unexpected result mean=%h col=%0d row=%0d done=%b",
						$time, mean_fixed, win_col, win_row, frame_done);
					errors <= errors + 1;
				end else begin
					e = mean_q.pop_front();
					if (e.mean !== mean_fixed || e.col !== win_col || e.row !== win_row ||
						e.done !== frame_done) begin
						$display("%0t: mismatch expected mean=%h col=%0d row=%0d done=%b",
							$time, e.mean, e.col, e.row, e.done);
						$display("%0t:          actual   mean=%h col=%0d row=%0d done=%b",
							$time, mean_fixed, win_col, win_row, frame_done);
						errors <= errors + 1;
					end
				end
			end
			outstanding <= mean_q.size();
		end
	end
endmodule
`default_nettype wire

/* tb/sv/tb_sliding_window_box_mean_unit.sv */
// Testbench top for the sliding window box mean unit: stimulus, stalls and verdict
`default_nettype none
module tb_sliding_window_box_mean_unit;
	import swbm_pkg::*;

	localparam int IDLE_LAT = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEM_TARGET = 1650;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = REG_WIN_COLS;
	logic [12:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  pixel = '0;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] mean_fixed;
	logic [9:0]  win_col;
	logic [11:0] win_row;
	logic        frame_done;
	int          errors, outstanding;
	int          pixels_sent = 0;
	int          idle_cycles = 0;
	int          out_hold = 0;
	bit          quiet = 1'b0;
	int          pix_mode = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sliding_window_box_mean_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .frame_start(frame_start),
		.out_valid(out_valid), .out_stall(out_stall), .mean_fixed(mean_fixed),
		.win_col(win_col), .win_row(win_row), .frame_done(frame_done)
	);

	swbm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .frame_start(frame_start),
		.out_valid(out_valid), .out_stall(out_stall), .mean_fixed(mean_fixed),
		.win_col(win_col), .win_row(win_row), .frame_done(frame_done),
		.errors(errors), .outstanding(outstanding)
	);

	// receiver stall: fresh hold count after every result transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) out_hold = quiet ? 0 : $urandom_range(0, 10);
			if (out_hold > 0) begin
				out_stall <= 1'b1;
				out_hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [7:0] draw_pixel();
		case (pix_mode)
			1: return 8'hFF;
			2: return 8'h00;
			3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_pixel(input logic [7:0] p, input logic fs);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		frame_start <= fs;
		do @(posedge clk); while (in_stall);
		pixels_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (IDLE_LAT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input int wc, input int wr, input int ic, input int ir);
		drain();
		write_reg(REG_WIN_COLS, 13'(wc));
		write_reg(REG_WIN_ROWS, 13'(wr));
		write_reg(REG_IMG_COLS, 13'(ic));
		write_reg(REG_IMG_ROWS, 13'(ir));
	endtask

	// send n pixels; the first carries frame_start when fs is set
	task automatic send_run(input int n, input bit fs);
		for (int i = 0; i < n; i++) send_pixel(draw_pixel(), fs && i == 0);
	endtask

	initial begin
		int wc, wr, ic, ir, frames, npix, cut;
		bit paused;
		paused = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 1x1 image, every pixel closes a frame
		set_geometry(1, 1, 1, 1);
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h80, 1'b0);
		// window taller than the image, zero width counts as one
		set_geometry(0, 31, 4, 3);
		send_run(12, 1'b1);
		// wrap to the next frame with no frame_start
		set_geometry(2, 2, 3, 2);
		pix_mode = 1;
		send_run(6, 1'b1);
		pix_mode = 3;
		send_run(6, 1'b0);
		// saturated image size, partial frame
		set_geometry(16, 1, 2047, 8191);
		pix_mode = 0;
		send_run(40, 1'b1);

		// full window of saturated size over a bright image
		set_geometry(16, 16, 16, 16);
		pix_mode = 1;
		send_run(256, 1'b1);

		while (pixels_sent < ITEM_TARGET) begin
			wc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
			wr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
			ic = $urandom_range(1, 20);
			ir = $urandom_range(1, 10);
			set_geometry(wc, wr, ic, ir);
			quiet = ($urandom_range(0, 3) == 0);
			pix_mode = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				npix = ic * ir;
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, npix) : npix;
				for (int i = 0; i < cut; i++) begin
					if (!paused && i == cut / 2 && cut > 4) begin
						// hold the sender until every result is out
						in_valid <= 1'b0;
						while (outstanding != 0) @(posedge clk);
						repeat (IDLE_LAT) @(posedge clk);
						paused = 1'b1;
					end
					send_pixel(draw_pixel(),
						(i == 0 && (f == 0 || cut != npix || $urandom_range(0, 1))) ||
						($urandom_range(0, 49) == 0));
				end
			end
		end
		quiet = 1'b0;
		drain();
		if (errors == 0 && outstanding == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
